// File: rtl/hrlp_pkg.sv
`default_nettype none

package hrlp_pkg;

  // Parser phase codes
  localparam logic [3:0] PH_METHOD      = 4'd0;
  localparam logic [3:0] PH_SP_METHOD   = 4'd1;
  localparam logic [3:0] PH_URI         = 4'd2;
  localparam logic [3:0] PH_SP_URI      = 4'd3;
  localparam logic [3:0] PH_H           = 4'd4;
  localparam logic [3:0] PH_HT          = 4'd5;
  localparam logic [3:0] PH_HTT         = 4'd6;
  localparam logic [3:0] PH_HTTP        = 4'd7;
  localparam logic [3:0] PH_SLASH       = 4'd8;
  localparam logic [3:0] PH_MAJOR_START = 4'd9;
  localparam logic [3:0] PH_MAJOR       = 4'd10;
  localparam logic [3:0] PH_DOT         = 4'd11;
  localparam logic [3:0] PH_AFTER_MINOR = 4'd12;
  localparam logic [3:0] PH_SP_VERSION  = 4'd13;

  // Item kinds
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_METHOD = 2'd1;
  localparam logic [1:0] KIND_URI    = 2'd2;

  // Error codes
  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_MISSING_URI = 4'd1;
  localparam logic [3:0] ERR_BAD_METHOD  = 4'd2;
  localparam logic [3:0] ERR_BAD_URI     = 4'd3;
  localparam logic [3:0] ERR_LITERAL     = 4'd4;
  localparam logic [3:0] ERR_NOT_DIGIT   = 4'd5;
  localparam logic [3:0] ERR_DOT_LAST    = 4'd6;
  localparam logic [3:0] ERR_JUNK        = 4'd7;
  localparam logic [3:0] ERR_BAD_VERSION = 4'd8;
  localparam logic [3:0] ERR_INCOMPLETE  = 4'd9;

  // Version codes
  localparam logic [2:0] VER_0_9 = 3'd0;
  localparam logic [2:0] VER_1_0 = 3'd1;
  localparam logic [2:0] VER_1_1 = 3'd2;
  localparam logic [2:0] VER_2_0 = 3'd3;
  localparam logic [2:0] VER_3_0 = 3'd4;

  // Characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  // Parser state carried from byte to byte
  typedef struct packed {
    logic [3:0] phase;
    logic [3:0] major;
    logic [3:0] minor;
    logic       method_nonempty;
    logic [3:0] sticky_error;
  } state_t;

  // One result item
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_out;
    logic       line_done;
    logic [3:0] error;
    logic [2:0] version;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase: PH_METHOD, major: 4'd0, minor: 4'd0,
    method_nonempty: 1'b0, sticky_error: ERR_NONE
  };

endpackage

`default_nettype wire

// File: rtl/http_request_line_parser_unit.sv
// HTTP request line parser.
// Input channel (in_*): one line byte per item in in_tdata, in_tlast set on
// the final byte of the line. Output channel (out_*): exactly one result
// item per input item, in order. out_tuser carries the kind (none, method
// byte, URI byte), out_tdata the passed byte, the error code and the version
// code; out_tlast marks the result of the line's final byte, which is the
// only item with a meaningful error and version.
// The byte sits in an input register, combinational phase logic computes the
// result and next parser state, and the result lands in the output register.
// Throughput: one byte per cycle while out_tready holds; the parser state
// feeds back through a single register, so items follow each other back to back.
// Reset clears both register stages and returns the parser to the method
// phase with no error pending. When the receiver stalls, the output register
// holds its item and the input register holds one more; in_tready falls only
// when both are full, and rises again in the cycle out_tready returns.
`default_nettype none

module http_request_line_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] byte_in
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] char_out, [11:8] error, [14:12] version
  output logic [1:0]       out_tuser,  // [1:0] kind
  output logic             out_tlast
);

  logic              in_vld_r;
  logic [7:0]        in_byte_r;
  logic              in_last_r;
  logic              out_vld_r;
  hrlp_pkg::result_t out_res_r;
  hrlp_pkg::state_t  state_r;
  hrlp_pkg::state_t  state_nxt;
  hrlp_pkg::result_t res_nxt;
  logic              adv;

  // Stage 1 item moves to the output register when that register frees up
  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  hrlp_step u_step (
    .byte_in (in_byte_r),
    .last    (in_last_r),
    .st      (state_r),
    .st_nxt  (state_nxt),
    .res     (res_nxt)
  );

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hrlp_pkg::STATE_RESET;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || out_tready) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_res_r.version, out_res_r.error, out_res_r.char_out};
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_res_r.line_done;

`ifndef SYNTH
  // Only the end-of-line item reports an error or a version
  a_report_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_res_r.line_done |->
      out_res_r.error == hrlp_pkg::ERR_NONE && out_res_r.version == 3'd0)
    else $error("error or version reported before end of line");

  // A nonzero version only comes with a clean line
  a_version_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.version != 3'd0 |->
      out_res_r.error == hrlp_pkg::ERR_NONE)
    else $error("version reported alongside an error");

  // A byte that is not passed through shows as zero
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.kind == hrlp_pkg::KIND_NONE |-> out_res_r.char_out == 8'd0)
    else $error("char_out nonzero with kind none");

  // End of line returns the parser to the method phase with no error
  a_line_reset: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_last_r |=>
      state_r.phase == hrlp_pkg::PH_METHOD && state_r.sticky_error == hrlp_pkg::ERR_NONE)
    else $error("parser state not cleared after end of line");

  // A pending error is kept until the line ends
  a_sticky_holds: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !in_last_r && state_r.sticky_error != hrlp_pkg::ERR_NONE |=>
      $stable(state_r.sticky_error))
    else $error("sticky error changed within a line");
`endif

endmodule

`default_nettype wire

// File: rtl/hrlp_step.sv
`default_nettype none

module hrlp_step (
  input  wire logic [7:0]      byte_in,
  input  wire logic            last,
  input  wire hrlp_pkg::state_t st,
  output hrlp_pkg::state_t     st_nxt,
  output hrlp_pkg::result_t    res
);

  function automatic logic is_blank(input logic [7:0] c);
    return (c == hrlp_pkg::CH_SPACE) || (c == hrlp_pkg::CH_TAB);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  // URI set: letters, digits, the unreserved / sub-delimiter marks and : @ / ?
  function automatic logic is_uri_char(input logic [7:0] c);
    logic ok;
    ok = is_upper(c) || ((c >= 8'h61) && (c <= 8'h7A)) || is_digit(c);
    case (c)
      8'h2D, 8'h2E, 8'h5F, 8'h7E, 8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29,
      8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D, 8'h3A, 8'h40, 8'h2F, 8'h3F: ok = 1'b1;
      default: ;
    endcase
    return ok;
  endfunction

  // Literal byte expected in each "HTTP/" phase
  function automatic logic [7:0] lit_char(input logic [3:0] ph);
    logic [7:0] ch;
    unique case (ph) inside
      hrlp_pkg::PH_SP_URI, hrlp_pkg::PH_H: ch = 8'h48;
      hrlp_pkg::PH_HT, hrlp_pkg::PH_HTT:   ch = 8'h54;
      hrlp_pkg::PH_HTTP:                   ch = 8'h50;
      default:                             ch = 8'h2F;
    endcase
    return ch;
  endfunction

  logic [3:0] byte_err;
  logic [7:0] major_acc;
  logic [3:0] line_err;
  logic [2:0] ver;
  logic       ver_ok;
  logic [1:0] kind;
  hrlp_pkg::state_t st_mid;

  // major * 10 + digit; digit value is the low nibble of an ASCII digit
  assign major_acc = {1'b0, st.major, 3'b000} + {3'b000, st.major, 1'b0}
                   + {4'd0, byte_in[3:0]};

  // Per-byte phase transition
  always_comb begin
    st_mid   = st;
    byte_err = hrlp_pkg::ERR_NONE;
    kind     = hrlp_pkg::KIND_NONE;
    if (st.sticky_error == hrlp_pkg::ERR_NONE) begin
      unique case (st.phase) inside
        hrlp_pkg::PH_METHOD: begin
          if (last) begin
            byte_err = hrlp_pkg::ERR_MISSING_URI;
          end else if (is_blank(byte_in)) begin
            if (!st.method_nonempty) byte_err = hrlp_pkg::ERR_INCOMPLETE;
            else                     st_mid.phase = hrlp_pkg::PH_SP_METHOD;
          end else if (!is_upper(byte_in)) begin
            byte_err = hrlp_pkg::ERR_BAD_METHOD;
          end else begin
            st_mid.method_nonempty = 1'b1;
            kind = hrlp_pkg::KIND_METHOD;
          end
        end
        hrlp_pkg::PH_SP_METHOD, hrlp_pkg::PH_URI: begin
          if (is_blank(byte_in)) begin
            if (st.phase == hrlp_pkg::PH_URI) st_mid.phase = hrlp_pkg::PH_SP_URI;
          end else if (!is_uri_char(byte_in)) begin
            byte_err = hrlp_pkg::ERR_BAD_URI;
          end else begin
            st_mid.phase = hrlp_pkg::PH_URI;
            kind         = hrlp_pkg::KIND_URI;
          end
        end
        hrlp_pkg::PH_SP_URI, hrlp_pkg::PH_H, hrlp_pkg::PH_HT, hrlp_pkg::PH_HTT,
        hrlp_pkg::PH_HTTP, hrlp_pkg::PH_SLASH: begin
          if (st.phase == hrlp_pkg::PH_SP_URI && is_blank(byte_in)) begin
            st_mid.phase = hrlp_pkg::PH_SP_URI;
          end else if (byte_in != lit_char(st.phase)) begin
            byte_err = hrlp_pkg::ERR_LITERAL;
          end else if (st.phase == hrlp_pkg::PH_SP_URI) begin
            st_mid.phase = hrlp_pkg::PH_HT;
          end else begin
            st_mid.phase = st.phase + 4'd1;
          end
        end
        hrlp_pkg::PH_MAJOR_START: begin
          if (!is_digit(byte_in)) begin
            byte_err = hrlp_pkg::ERR_NOT_DIGIT;
          end else begin
            st_mid.major = byte_in[3:0];
            st_mid.phase = hrlp_pkg::PH_MAJOR;
          end
        end
        hrlp_pkg::PH_MAJOR: begin
          if (byte_in == hrlp_pkg::CH_DOT) begin
            if (last) byte_err = hrlp_pkg::ERR_DOT_LAST;
            else      st_mid.phase = hrlp_pkg::PH_DOT;
          end else if (!is_digit(byte_in)) begin
            byte_err = hrlp_pkg::ERR_NOT_DIGIT;
          end else begin
            // saturate the major number at 15
            st_mid.major = (major_acc > 8'd15) ? 4'd15 : major_acc[3:0];
          end
        end
        hrlp_pkg::PH_DOT: begin
          if (!is_digit(byte_in)) begin
            byte_err = hrlp_pkg::ERR_NOT_DIGIT;
          end else begin
            st_mid.minor = byte_in[3:0];
            st_mid.phase = hrlp_pkg::PH_AFTER_MINOR;
          end
        end
        hrlp_pkg::PH_AFTER_MINOR, hrlp_pkg::PH_SP_VERSION: begin
          if (!is_blank(byte_in)) byte_err = hrlp_pkg::ERR_JUNK;
          else                    st_mid.phase = hrlp_pkg::PH_SP_VERSION;
        end
        default: begin
          st_mid.phase = hrlp_pkg::PH_METHOD;
          byte_err     = hrlp_pkg::ERR_INCOMPLETE;
        end
      endcase
      if (byte_err != hrlp_pkg::ERR_NONE) begin
        st_mid.sticky_error = byte_err;
        kind                = hrlp_pkg::KIND_NONE;
      end
    end
  end

  // Version lookup on the final major/minor pair
  always_comb begin
    ver_ok = 1'b1;
    ver    = hrlp_pkg::VER_0_9;
    if      (st_mid.major == 4'd0 && st_mid.minor == 4'd9) ver = hrlp_pkg::VER_0_9;
    else if (st_mid.major == 4'd1 && st_mid.minor == 4'd0) ver = hrlp_pkg::VER_1_0;
    else if (st_mid.major == 4'd1 && st_mid.minor == 4'd1) ver = hrlp_pkg::VER_1_1;
    else if (st_mid.major == 4'd2 && st_mid.minor == 4'd0) ver = hrlp_pkg::VER_2_0;
    else if (st_mid.major == 4'd3 && st_mid.minor == 4'd0) ver = hrlp_pkg::VER_3_0;
    else ver_ok = 1'b0;
  end

  // End-of-line report and state return
  always_comb begin
    line_err = st_mid.sticky_error;
    if (line_err == hrlp_pkg::ERR_NONE &&
        st_mid.phase != hrlp_pkg::PH_AFTER_MINOR &&
        st_mid.phase != hrlp_pkg::PH_SP_VERSION) begin
      line_err = hrlp_pkg::ERR_INCOMPLETE;
    end
    if (line_err == hrlp_pkg::ERR_NONE && !ver_ok) line_err = hrlp_pkg::ERR_BAD_VERSION;

    res.kind      = kind;
    res.char_out  = (kind != hrlp_pkg::KIND_NONE) ? byte_in : 8'd0;
    res.line_done = last;
    res.error     = last ? line_err : hrlp_pkg::ERR_NONE;
    res.version   = (last && line_err == hrlp_pkg::ERR_NONE) ? ver : 3'd0;
    st_nxt        = last ? hrlp_pkg::STATE_RESET : st_mid;
  end

endmodule

`default_nettype wire
